FILE: sv/deq_pkg.sv
package deq_pkg;

    // Queue geometry
    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;

    // Operation codes carried by an input transaction
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic             en;
        t_op              op;
        logic [CNT_W-1:0] count;
    } t_cell_cmd;

endpackage

FILE: sv/deq_cell.sv
module deq_cell (
    input  logic                       i_clk,
    input  logic [deq_pkg::IDX_W-1:0]  i_index,
    input  deq_pkg::t_cell_cmd         i_cmd,
    input  logic [deq_pkg::KEY_W-1:0]  i_key,
    input  logic [deq_pkg::KEY_W-1:0]  i_left_data,
    input  logic [deq_pkg::KEY_W-1:0]  i_right_data,
    output logic [deq_pkg::KEY_W-1:0]  o_data,
    output logic [deq_pkg::KEY_W-1:0]  o_tap
);
    import deq_pkg::*;

    logic [KEY_W-1:0] r_data;
    logic [KEY_W-1:0] n_data;
    logic [CNT_W-1:0] w_pos;
    logic             w_is_tail;
    logic             w_is_free;

    // Position of this cell relative to the current fill level
    assign w_pos     = {1'b0, i_index};
    assign w_is_free = (w_pos == i_cmd.count);
    assign w_is_tail = (w_pos == i_cmd.count - CNT_W'(1));

    // Shift toward the back, take the key, shift toward the front or hold
    always_comb begin
        n_data = r_data;
        if (i_cmd.en) begin
            unique case (i_cmd.op)
                OP_PUSH_FRONT: n_data = i_left_data;
                OP_PUSH_BACK: begin
                    if (w_is_free) begin
                        n_data = i_key;
                    end
                end
                OP_POP_FRONT:  n_data = i_right_data;
                OP_POP_BACK:   n_data = r_data;
                default:       n_data = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // Drive the back element onto the gather bus on a back pop
    assign o_tap = (i_cmd.en && i_cmd.op == OP_POP_BACK && w_is_tail) ? r_data : '0;

endmodule

FILE: sv/double_ended_queue.sv
// Bounded double-ended queue of 64 signed 32-bit keys. The keys sit in a row of cells
// ordered from front (cell 0) to back; a push at the front shifts the whole row one cell
// toward the back in the same cycle, a pop at the front shifts it one cell toward the
// front, and back operations touch only the cell at the fill level. Each input
// transaction (push front, push back, pop front, pop back) yields exactly one result
// transaction with the popped key (zero when nothing was popped), a status (ok, empty on
// pop, full on push with the key dropped) and the element count after the operation.
// One operation is accepted every cycle while input stall is low; its result appears in the
// output register on the next cycle. Input stall is raised only while a finished result waits
// and the output side stalls it.
module double_ended_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic signed [31:0]        i_key,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [31:0]        o_popped_key,
    output logic [1:0]                o_status,
    output logic [6:0]                o_element_count
);
    import deq_pkg::*;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    logic             w_is_push;
    t_op              w_op;
    t_status          w_status;
    t_cell_cmd        w_cmd;
    logic [KEY_W-1:0] w_popped;
    logic [KEY_W-1:0] w_gather;
    logic [KEY_W-1:0] w_data [DEPTH];
    logic [KEY_W-1:0] w_tap  [DEPTH];

    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [KEY_W-1:0] r_popped;
    t_status          r_status;

    // Take a transaction when the result register is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_op      = t_op'(i_operation);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_is_push = (w_op == OP_PUSH_FRONT) || (w_op == OP_PUSH_BACK);

    // Decide status and build the row command
    always_comb begin
        if (w_is_push) begin
            w_status = w_full ? ST_FULL : ST_OK;
        end else begin
            w_status = w_empty ? ST_EMPTY : ST_OK;
        end
        w_cmd.en    = w_accept && (w_status == ST_OK);
        w_cmd.op    = w_op;
        w_cmd.count = r_count;
    end

    // Row of cells, front at index zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_left;
        logic [KEY_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = KEY_W'(i_key);
        end else begin : g_body
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end

        deq_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_cmd        (w_cmd),
            .i_key        (KEY_W'(i_key)),
            .i_left_data  (w_left),
            .i_right_data (w_right),
            .o_data       (w_data[g]),
            .o_tap        (w_tap[g])
        );
    end

    // Collect the back element; only the tail cell drives a nonzero tap
    always_comb begin
        w_gather = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_gather = w_gather | w_tap[i];
        end
    end

    // Select the popped key
    always_comb begin
        w_popped = '0;
        if (w_cmd.en) begin
            case (w_op)
                OP_POP_FRONT: w_popped = w_data[0];
                OP_POP_BACK:  w_popped = w_gather;
                default:      w_popped = '0;
            endcase
        end
    end

    // Advance the element count
    always_comb begin
        n_count = r_count;
        if (w_cmd.en) begin
            if (w_is_push) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    // Hold the result until the output side takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= w_popped;
            r_status <= w_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_popped_key    = $signed(r_popped);
    assign o_status        = r_status;
    assign o_element_count = 7'(r_count);

`ifndef SYNTH
    // Fill level never exceeds the row length
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    // A dropped push reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // An empty pop reports an empty queue
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with elements held");

    // A rejected operation returns no key
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_OK) |-> (r_popped == '0))
        else $error("nonzero key on rejected operation");

    // Count is unchanged when no operation is applied
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cmd.en |=> $stable(r_count))
        else $error("count moved without an operation");
`endif

endmodule

FILE: tb/sv/double_ended_queue_tb.sv
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int OPS_PER_PHASE = 250;
    localparam int DRAIN_CYCLES = 8;

    // One queued input transaction
    typedef struct {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
    } t_deq_op;

    // One predicted result transaction
    typedef struct {
        logic signed [KEY_W-1:0] popped;
        t_status                 status;
        logic [CNT_W-1:0]        count;
    } t_deq_result;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [1:0]              i_operation = OP_PUSH_BACK;
    logic signed [KEY_W-1:0] i_key = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [KEY_W-1:0] o_popped_key;
    logic [1:0]              o_status;
    logic [6:0]              o_element_count;

    // Stimulus backlog and results still owed by the block
    t_deq_op     op_backlog[$];
    t_deq_result awaited_results[$];

    // Shadow copy of the queue contents
    logic signed [KEY_W-1:0] ring_keys [DEPTH];
    logic [IDX_W-1:0]        head_slot = '0;
    logic [IDX_W-1:0]        tail_slot = '0;
    logic [CNT_W-1:0]        held_count = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int results_checked = 0;
    int full_drops = 0;
    int empty_pops = 0;
    int keys_popped = 0;
    int full_hits = 0;

    double_ended_queue dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_key           (i_key),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_popped_key    (o_popped_key),
        .o_status        (o_status),
        .o_element_count (o_element_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the shadow queue by one operation and return the result it owes
    function automatic t_deq_result apply_deque_op(t_op op, logic signed [KEY_W-1:0] key);
        t_deq_result res;
        res.popped = '0;
        res.status = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (held_count >= CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
                full_drops++;
            end else if (op == OP_PUSH_FRONT) begin
                head_slot = (head_slot == '0) ? IDX_W'(DEPTH - 1) : head_slot - 1'b1;
                ring_keys[head_slot] = key;
                held_count++;
            end else begin
                ring_keys[tail_slot] = key;
                tail_slot = (tail_slot == IDX_W'(DEPTH - 1)) ? '0 : tail_slot + 1'b1;
                held_count++;
            end
            if (held_count == CNT_W'(DEPTH) && res.status == ST_OK) full_hits++;
        end else begin
            if (held_count == '0) begin
                res.status = ST_EMPTY;
                empty_pops++;
            end else begin
                if (op == OP_POP_FRONT) begin
                    res.popped = ring_keys[head_slot];
                    head_slot = (head_slot == IDX_W'(DEPTH - 1)) ? '0 : head_slot + 1'b1;
                end else begin
                    tail_slot = (tail_slot == '0) ? IDX_W'(DEPTH - 1) : tail_slot - 1'b1;
                    res.popped = ring_keys[tail_slot];
                end
                held_count--;
                keys_popped++;
                // last element gone: both ends restart at slot zero
                if (held_count == '0) begin
                    head_slot = '0;
                    tail_slot = '0;
                end
            end
        end
        res.count = held_count;
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(t_op op, logic signed [KEY_W-1:0] key);
        t_deq_op entry;
        entry.op = op;
        entry.key = key;
        op_backlog.push_back(entry);
    endtask

    // Queue random runs that fill, drain, flood or mix the queue
    task automatic queue_random_ops(int total);
        int left;
        int run;
        int push_pct;
        t_op op;
        left = total;
        while (left > 0) begin
            case ($urandom_range(9))
                0, 1, 2: begin push_pct = 90;  run = $urandom_range(90, 20); end
                3, 4, 5: begin push_pct = 10;  run = $urandom_range(90, 20); end
                6, 7:    begin push_pct = 50;  run = $urandom_range(40, 5);  end
                8:       begin push_pct = 100; run = $urandom_range(72, 66); end
                default: begin push_pct = 0;   run = $urandom_range(72, 66); end
            endcase
            if (run > left) run = left;
            for (int n = 0; n < run; n++) begin
                if ($urandom_range(99) < push_pct)
                    op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
                queue_op(op, pick_key());
            end
            left -= run;
        end
    endtask

    // Extremes, both empty pops, last-element pops and front index wrap
    task automatic queue_directed_ops();
        queue_op(OP_POP_FRONT, 32'h1111_1111);
        queue_op(OP_POP_BACK, 32'h2222_2222);
        queue_op(OP_PUSH_BACK, 32'h7FFF_FFFF);
        queue_op(OP_PUSH_FRONT, 32'h8000_0000);
        queue_op(OP_PUSH_BACK, '0);
        queue_op(OP_PUSH_FRONT, '1);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_BACK, '1);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_PUSH_FRONT, 32'sd1);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_PUSH_BACK, 32'h5555_5555);
        queue_op(OP_PUSH_BACK, 32'hAAAA_AAAA);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_PUSH_FRONT, 32'h1234_5678);
        queue_op(OP_POP_FRONT, '0);
        queue_op(OP_POP_FRONT, '0);
    endtask

    // Drive input transactions from the backlog, holding while stalled
    always @(posedge i_clk) begin : drive_ops
        t_deq_op nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                awaited_results.push_back(apply_deque_op(t_op'(i_operation), i_key));
            if (!i_in_valid || !o_in_stall) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= nxt.op;
                    i_key <= nxt.key;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_deq_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result transaction with nothing awaited");
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (o_popped_key !== want.popped) begin
                    $error("popped_key: expected %0d, got %0d", want.popped, o_popped_key);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_element_count !== want.count) begin
                    $error("element_count: expected %0d, got %0d", want.count,
                           o_element_count);
                    error_count++;
                end
            end
        end
    end

    // Hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Reset, then run the idling phases and close out
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            if (phase == 0) queue_directed_ops();
            queue_random_ops(OPS_PER_PHASE);
            while (op_backlog.size() != 0) @(negedge i_clk);
        end
        while (i_in_valid) @(negedge i_clk);
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("checked %0d results over four idling phases: %0d keys popped,", results_checked,
                 keys_popped);
        $display("queue filled %0d times, %0d pushes dropped when full, %0d pops on empty",
                 full_hits, full_drops, empty_pops);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
